FILE: rtl/bao_pkg.sv
// shared types and constants for the bgra alpha over blend pipeline
// no dependencies; used by every module under rtl
`default_nettype none

package bao_pkg;

  localparam logic [7:0] ChMax      = 8'd255;
  localparam logic [8:0] WOne       = 9'd256;
  localparam int         RecipShift = 16;
  localparam int         PipeDepth  = 7;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] tgt;
    logic [7:0]  da;
    logic [7:0]  q;
  } bao_alpha_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] tgt;
    logic [7:0]  da;
    logic [8:0]  w;
  } bao_weight_t;

endpackage

`default_nettype wire

FILE: rtl/bao_alpha.sv
// result alpha stages: target alpha scaling and exact divide by 255
// depends on bao_pkg
`default_nettype none

module bao_alpha (
  input  wire logic                clk,
  input  wire logic [1:0]          en,
  input  wire logic [31:0]         source_pixel,
  input  wire logic [31:0]         target_pixel,
  output bao_pkg::bao_alpha_t      aout
);

  logic [31:0] src1;
  logic [31:0] tgt1;
  logic [15:0] p1;
  logic [15:0] p_next;

  logic [23:0] t_mul;
  logic [7:0]  q0;
  logic [16:0] rem;
  logic [7:0]  q;
  logic [8:0]  da_sum;

  assign p_next = 16'(target_pixel[31:24]) * 16'(bao_pkg::ChMax - source_pixel[31:24]);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      src1 <= source_pixel;
      tgt1 <= target_pixel;
      p1   <= p_next;
    end
  end

  // divide by 255: multiply by 257 over 2^16, then one correction
  assign t_mul  = {p1, 8'd0} + 24'(p1);
  assign q0     = t_mul[23:16];
  assign rem    = 17'(p1) + 17'(q0) - {1'b0, q0, 8'd0};
  assign q      = q0 + 8'(rem >= 17'(bao_pkg::ChMax));
  assign da_sum = 9'(src1[31:24]) + 9'(q);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      aout.src <= src1;
      aout.tgt <= tgt1;
      aout.q   <= q;
      aout.da  <= da_sum[7:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bao_weight.sv
// weight stages: s = floor(q*256/da) by reciprocal table, multiply and correction
// depends on bao_pkg
`default_nettype none

module bao_weight (
  input  wire logic                clk,
  input  wire logic [2:0]          en,
  input  wire bao_pkg::bao_alpha_t ain,
  output bao_pkg::bao_weight_t     wout
);

  logic [16:0] rtab [256];

  assign rtab[0] = 17'd0;
  for (genvar d = 1; d < 256; d++) begin : g_rcp
    localparam logic [16:0] Rv = 17'((1 << bao_pkg::RecipShift) / d);
    assign rtab[d] = Rv;
  end

  logic [31:0] src3, tgt3, src4, tgt4;
  logic [7:0]  da3, q3, da4, q4;
  logic [24:0] m3;
  logic [24:0] m_next;
  logic [8:0]  w4;
  logic [16:0] prod4;
  logic [15:0] num;
  logic [16:0] rem;

  assign m_next = 25'(ain.q) * 25'(rtab[ain.da]);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      src3 <= ain.src;
      tgt3 <= ain.tgt;
      da3  <= ain.da;
      q3   <= ain.q;
      m3   <= m_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      src4  <= src3;
      tgt4  <= tgt3;
      da4   <= da3;
      q4    <= q3;
      w4    <= m3[16:8];
      prod4 <= 17'(m3[16:8]) * 17'(da3);
    end
  end

  // estimate is at most one low
  assign num = {q4, 8'd0};
  assign rem = 17'(num) - prod4;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      wout.src <= src4;
      wout.tgt <= tgt4;
      wout.da  <= da4;
      wout.w   <= w4 + 9'(rem >= 17'(da4));
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bao_mix.sv
// colour mix stages: weighted products per channel, sum and pack
// depends on bao_pkg
`default_nettype none

module bao_mix (
  input  wire logic                 clk,
  input  wire logic [1:0]           en,
  input  wire bao_pkg::bao_weight_t win,
  output logic [31:0]               blended_pixel
);

  logic [16:0] a6 [3];
  logic [16:0] b6 [3];
  logic [7:0]  da6;
  logic [8:0]  wi;
  logic [7:0]  ch [3];
  logic [17:0] sum [3];

  assign wi = bao_pkg::WOne - win.w;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      da6 <= win.da;
      for (int i = 0; i < 3; i++) begin
        a6[i] <= 17'(wi) * 17'(win.src[8*i +: 8]);
        b6[i] <= 17'(win.w) * 17'(win.tgt[8*i +: 8]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = 18'(a6[i]) + 18'(b6[i]);
      ch[i]  = sum[i][15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      blended_pixel <= (da6 == 8'd0) ? 32'd0 : {da6, ch[2], ch[1], ch[0]};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bgra_alpha_over_blend.sv
// top level of the bgra alpha over blend: valid and ready control over seven stages
// depends on bao_pkg, bao_alpha, bao_weight, bao_mix
//
// channel   direction  payload
// s_axis    in         tdata = source pixel, target pixel; tlast = last pixel mark
// m_axis    out        tdata = blended pixel; tlast = last pixel mark
//
// one request per cycle sustained while m_axis_tready stays high; seven register stages,
// the last of which is the output register
// the stages carry the divide by 255, the reciprocal weight and its correction, and the mix
// each stage moves when it is empty or the next one moves, so bubbles close up
// rst clears the valid bits only; data registers keep whatever they hold
`default_nettype none

module bgra_alpha_over_blend (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // source_pixel [31:0], target_pixel [63:32]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // blended_pixel [31:0]
  output logic             m_axis_tlast
);

  localparam int Depth = bao_pkg::PipeDepth;

  logic [Depth-1:0]     valid;
  logic [Depth-1:0]     last;
  logic [Depth-1:0]     en;
  bao_pkg::bao_alpha_t  alpha;
  bao_pkg::bao_weight_t weight;

  always_comb begin
    en[Depth-1] = !valid[Depth-1] || m_axis_tready;
    for (int i = Depth - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < Depth; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      last[0] <= s_axis_tlast;
    end
    for (int i = 1; i < Depth; i++) begin
      if (en[i]) begin
        last[i] <= last[i-1];
      end
    end
  end

  bao_alpha u_alpha (
    .clk          (clk),
    .en           (en[1:0]),
    .source_pixel (s_axis_tdata[31:0]),
    .target_pixel (s_axis_tdata[63:32]),
    .aout         (alpha)
  );

  bao_weight u_weight (
    .clk  (clk),
    .en   (en[4:2]),
    .ain  (alpha),
    .wout (weight)
  );

  bao_mix u_mix (
    .clk           (clk),
    .en            (en[6:5]),
    .win           (weight),
    .blended_pixel (m_axis_tdata)
  );

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = valid[Depth-1];
  assign m_axis_tlast  = last[Depth-1];

  a_empty_takes_input: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("empty output stage but input held off");

  a_zero_alpha_blank: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[31:24] == 8'd0 |-> m_axis_tdata == 32'd0)
    else $error("zero alpha request carries colour");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

`default_nettype wire

FILE: dv/bgra_alpha_over_blend_tb.sv
// self-checking bench for bgra_alpha_over_blend: directed corner pixels, then random
// pixel pairs under three idling phases, each result checked against a local blend model
// depends on bao_pkg and the bgra_alpha_over_blend rtl
`timescale 1ns / 100ps

module bgra_alpha_over_blend_tb;

  localparam int unsigned ChFull     = 255;
  localparam int unsigned WeightOne  = 256;
  localparam int          CycleLimit = 400000;
  localparam int          SettleCyc  = 4 * bao_pkg::PipeDepth + 8;

  typedef struct {
    logic [31:0] src;
    logic [31:0] tgt;
    logic        last;
  } pixel_pair_t;

  typedef struct {
    logic [31:0] pixel;
    logic        last;
  } blend_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // source_pixel [31:0], target_pixel [63:32]
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // blended_pixel [31:0]
  logic        m_axis_tlast;

  pixel_pair_t   pending_pairs[$];
  blend_result_t expected_blends[$];
  int            src_idle_pct = 24;
  int            sink_idle_pct = 57;
  bit            req_taken = 1'b0;
  int            mismatches = 0;
  int            cycle_count = 0;

  bgra_alpha_over_blend dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] over_blend(logic [31:0] src, logic [31:0] tgt);
    int unsigned sa;
    int unsigned ta;
    int unsigned da;
    int unsigned w;
    logic [31:0] res;
    sa = 32'(src[31:24]);
    ta = 32'(tgt[31:24]);
    da = sa + (ta * (ChFull - sa)) / ChFull;
    res = '0;
    if (da != 0) begin
      w = ((da - sa) * WeightOne) / da;
      for (int c = 0; c < 3; c++) begin
        res[8*c +: 8] = 8'(((WeightOne - w) * 32'(src[8*c +: 8])
                            + w * 32'(tgt[8*c +: 8])) / WeightOne);
      end
      res[31:24] = da[7:0];
    end
    return res;
  endfunction

  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'(($urandom_range(1, 3)));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_pair(logic [31:0] src, logic [31:0] tgt, logic last);
    pixel_pair_t p;
    p.src  = src;
    p.tgt  = tgt;
    p.last = last;
    pending_pairs.push_back(p);
  endtask

  task automatic push_random(int count);
    logic [31:0] src;
    logic [31:0] tgt;
    for (int i = 0; i < count; i++) begin
      src = $urandom;
      tgt = $urandom;
      src[31:24] = pick_alpha();
      tgt[31:24] = pick_alpha();
      push_pair(src, tgt, $urandom_range(0, 15) == 0);
    end
  endtask

  // waits until every queued pair is sent and every outstanding result is back
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_pairs.size() != 0 || s_axis_tvalid || expected_blends.size() != 0);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // request side: record accepted requests and predict their blends
  always @(posedge clk) begin : track_requests
    blend_result_t r;
    req_taken = !rst && s_axis_tvalid && s_axis_tready;
    if (req_taken) begin
      r.pixel = over_blend(s_axis_tdata[31:0], s_axis_tdata[63:32]);
      r.last  = s_axis_tlast;
      expected_blends.push_back(r);
    end
  end

  // result side
  always @(posedge clk) begin : check_results
    blend_result_t r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_blends.size() == 0) begin
        $error("unexpected result: blended_pixel %h last_out %b", m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        r = expected_blends.pop_front();
        if (m_axis_tdata !== r.pixel) begin
          $error("blended_pixel: expected %h, got %h", r.pixel, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tlast !== r.last) begin
          $error("last_out: expected %b, got %b", r.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk) begin : drive_requests
    pixel_pair_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || req_taken) begin
        if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          nxt = pending_pairs.pop_front();
          s_axis_tdata  <= {nxt.tgt, nxt.src};
          s_axis_tlast  <= nxt.last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= $urandom_range(0, 99) >= sink_idle_pct;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero result alpha, with and without colour in the inputs
    push_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
    push_pair(32'h00FF_FFFF, 32'h00FF_FFFF, 1'b1);
    push_pair(32'h0012_3456, 32'h00AB_CDEF, 1'b0);
    // opaque source
    push_pair(32'hFF12_3456, 32'hFFAB_CDEF, 1'b0);
    push_pair(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    push_pair(32'hFF00_0000, 32'hFFFF_FFFF, 1'b0);
    // transparent source over opaque or faint target
    push_pair(32'h00FF_FFFF, 32'hFF00_0000, 1'b0);
    push_pair(32'h0011_2233, 32'hFFCC_DDEE, 1'b0);
    push_pair(32'h00FF_00FF, 32'h0100_FF00, 1'b1);
    push_pair(32'h0000_0000, 32'h01FF_FFFF, 1'b0);
    // faint, mid and high alphas
    push_pair(32'h01FF_FFFF, 32'h0100_0000, 1'b0);
    push_pair(32'h0100_0000, 32'h01FF_FFFF, 1'b0);
    push_pair(32'h80FF_00FF, 32'h8000_FF00, 1'b1);
    push_pair(32'h7F80_8080, 32'h807F_7F7F, 1'b0);
    push_pair(32'hFEFF_FFFF, 32'hFE00_0000, 1'b0);
    push_pair(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    push_pair(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    push_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    push_pair(32'h01FF_FFFF, 32'hFFFF_FFFF, 1'b0);
    push_pair(32'hFE00_0000, 32'h01FF_FFFF, 1'b0);
    wait_drained();

    push_random(600);
    wait_drained();

    src_idle_pct  = 57;
    sink_idle_pct = 24;
    push_random(600);
    wait_drained();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    push_random(550);
    wait_drained();

    repeat (SettleCyc) @(posedge clk);
    if (mismatches == 0 && expected_blends.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bao_pkg.sv
rtl/bao_alpha.sv
rtl/bao_weight.sv
rtl/bao_mix.sv
rtl/bgra_alpha_over_blend.sv
dv/bgra_alpha_over_blend_tb.sv
